FILE: rtl/s3i_pkg.sv
// shared types for the symmetric 3x3 inverse pipeline
package s3i_pkg;

    // per-entry control that travels down the divider stages
    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
        logic sing;
    } s3i_div_ctl_t;

endpackage

FILE: rtl/s3i_if.sv
// valid/ready channel interfaces for matrix beats and inverse beats
interface s3i_in_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a00;
    logic signed [W-1:0] a01;
    logic signed [W-1:0] a02;
    logic signed [W-1:0] a11;
    logic signed [W-1:0] a12;
    logic signed [W-1:0] a22;

    modport source (output valid, output a00, output a01, output a02,
                    output a11, output a12, output a22, input ready);
    modport sink   (input valid, input a00, input a01, input a02,
                    input a11, input a12, input a22, output ready);
endinterface

interface s3i_out_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] inv00;
    logic signed [W-1:0] inv01;
    logic signed [W-1:0] inv02;
    logic signed [W-1:0] inv11;
    logic signed [W-1:0] inv12;
    logic signed [W-1:0] inv22;
    logic                singular;
    logic                saturated;

    modport source (output valid, output inv00, output inv01, output inv02,
                    output inv11, output inv12, output inv22,
                    output singular, output saturated, input ready);
    modport sink   (input valid, input inv00, input inv01, input inv02,
                    input inv11, input inv12, input inv22,
                    input singular, input saturated, output ready);
endinterface

FILE: rtl/symmetric_3x3_inverse.sv
// symmetric 3x3 inverse, fully pipelined
// throughput one matrix beat per cycle; the whole pipeline holds on output stall
// six cofactor/determinant stages, then one restoring quotient bit per stage,
// six division lanes side by side, then a saturating output register
// rst_n asynchronously clears every valid bit; data registers are not reset
module symmetric_3x3_inverse #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    s3i_in_if.sink     mat,
    s3i_out_if.source  inv
);
    import s3i_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = 2 * W + 1;
    localparam int DTW = 3 * W + 2;
    localparam int NW  = CW + 2 * F;
    localparam int SW  = DTW + W;
    localparam int DW  = (NW > SW) ? NW : SW;

    logic en;
    logic out_valid_reg;
    logic [5:0] fv_reg;

    logic signed [2*W-1:0] p_reg   [12];
    logic signed [W-1:0]   r1_reg  [3];
    logic signed [W-1:0]   r2_reg  [3];
    logic signed [CW-1:0]  c2_reg  [6];
    logic signed [CW-1:0]  c3_reg  [6];
    logic signed [CW-1:0]  c4_reg  [6];
    logic signed [CW-1:0]  c5_reg  [6];
    logic signed [CW-1:0]  lo_reg  [3];
    logic signed [CW-1:0]  hi_reg  [3];
    logic signed [DTW-1:0] t4_reg  [3];
    logic signed [DTW-1:0] det5_reg;
    logic [DTW-1:0]        dm6_reg;
    logic [CW-1:0]         nm6_reg [6];
    logic [5:0]            neg6_reg;
    logic                  sing6_reg;

    logic [DW-1:0]  rem_p [W+1][6];
    logic [W-1:0]   q_p   [W+1][6];
    s3i_div_ctl_t   ctl_p [W+1][6];
    logic [DW-1:0]  d_p   [W+1];

    logic [DW-1:0]  num_next [6];
    logic [DW-1:0]  dlim_next;

    logic signed [W-1:0] res_next [6];
    logic [5:0]          sat_next;
    logic signed [W-1:0] res_reg  [6];
    logic                sing_reg;
    logic                sat_reg;

    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

    // whole pipeline advances unless a finished beat is held
    assign en        = !out_valid_reg || inv.ready;
    assign mat.ready = en;

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[4:0], mat.valid};
        end
    end

    // stage 1: twelve pairwise products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= mat.a11 * mat.a22;
            p_reg[1]  <= mat.a12 * mat.a12;
            p_reg[2]  <= mat.a12 * mat.a02;
            p_reg[3]  <= mat.a01 * mat.a22;
            p_reg[4]  <= mat.a01 * mat.a12;
            p_reg[5]  <= mat.a11 * mat.a02;
            p_reg[6]  <= mat.a00 * mat.a22;
            p_reg[7]  <= mat.a02 * mat.a02;
            p_reg[8]  <= mat.a01 * mat.a02;
            p_reg[9]  <= mat.a12 * mat.a00;
            p_reg[10] <= mat.a00 * mat.a11;
            p_reg[11] <= mat.a01 * mat.a01;
            r1_reg[0] <= mat.a00;
            r1_reg[1] <= mat.a01;
            r1_reg[2] <= mat.a02;
        end
    end

    // stage 2: cofactors; stage 3: row-0 products split at bit W; stage 4: recombined row-0 terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                c2_reg[i] <= CW'(p_reg[2*i]) - CW'(p_reg[2*i+1]);
                c3_reg[i] <= c2_reg[i];
                c4_reg[i] <= c3_reg[i];
                c5_reg[i] <= c4_reg[i];
            end
            for (int r = 0; r < 3; r++)
            begin
                r2_reg[r] <= r1_reg[r];
                lo_reg[r] <= r2_reg[r] * $signed({1'b0, c2_reg[r][W-1:0]});
                hi_reg[r] <= r2_reg[r] * $signed(c2_reg[r][CW-1:W]);
                t4_reg[r] <= (DTW'(hi_reg[r]) <<< W) + DTW'(lo_reg[r]);
            end
            // stage 5: determinant by expansion along row 0
            det5_reg <= t4_reg[0] + t4_reg[1] + t4_reg[2];
        end
    end

    // stage 6: magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm6_reg   <= det5_reg[DTW-1] ? DTW'(-det5_reg) : DTW'(det5_reg);
            sing6_reg <= (det5_reg == '0);
            for (int i = 0; i < 6; i++)
            begin
                nm6_reg[i]  <= c5_reg[i][CW-1] ? CW'(-c5_reg[i]) : CW'(c5_reg[i]);
                neg6_reg[i] <= c5_reg[i][CW-1] ^ det5_reg[DTW-1];
            end
        end
    end

    // stage 7: scaled numerator and overflow check against divisor << W
    always_comb
    begin
        dlim_next = DW'(dm6_reg) << W;
        for (int i = 0; i < 6; i++)
        begin
            num_next[i] = DW'(nm6_reg[i]) << (2 * F);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                ctl_p[0][i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                ctl_p[0][i].valid <= fv_reg[5];
                ctl_p[0][i].neg   <= neg6_reg[i];
                ctl_p[0][i].ovf   <= (num_next[i] >= dlim_next);
                ctl_p[0][i].sing  <= sing6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_p[0] <= DW'(dm6_reg);
            for (int i = 0; i < 6; i++)
            begin
                rem_p[0][i] <= num_next[i];
                q_p[0][i]   <= '0;
            end
        end
    end

    // divisor rides alongside the division lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < W; j++)
            begin
                d_p[j+1] <= d_p[j];
            end
        end
    end

    // one quotient bit per stage, msb first, six lanes
    for (genvar j = 0; j < W; j++)
    begin : g_step
        for (genvar i = 0; i < 6; i++)
        begin : g_lane
            s3i_div_step #(
                .W  (W),
                .DW (DW),
                .K  (W - 1 - j)
            ) u_step (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .rem_in  (rem_p[j][i]),
                .dvs_in  (d_p[j]),
                .q_in    (q_p[j][i]),
                .ctl_in  (ctl_p[j][i]),
                .rem_out (rem_p[j+1][i]),
                .q_out   (q_p[j+1][i]),
                .ctl_out (ctl_p[j+1][i])
            );
        end
    end

    // sign, saturation and singular masking
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            res_next[i] = '0;
            sat_next[i] = 1'b0;
            if (ctl_p[W][i].sing)
            begin
                res_next[i] = '0;
                sat_next[i] = 1'b0;
            end
            else if (!ctl_p[W][i].neg)
            begin
                if (ctl_p[W][i].ovf || q_p[W][i][W-1])
                begin
                    res_next[i] = MAXPOS;
                    sat_next[i] = 1'b1;
                end
                else
                begin
                    res_next[i] = q_p[W][i];
                end
            end
            else
            begin
                if (ctl_p[W][i].ovf || (q_p[W][i][W-1] && (|q_p[W][i][W-2:0])))
                begin
                    res_next[i] = MINNEG;
                    sat_next[i] = 1'b1;
                end
                else
                begin
                    res_next[i] = W'(-q_p[W][i]);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_p[W][0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            sing_reg <= ctl_p[W][0].sing;
            sat_reg  <= |sat_next;
        end
    end

    assign inv.valid     = out_valid_reg;
    assign inv.inv00     = res_reg[0];
    assign inv.inv01     = res_reg[1];
    assign inv.inv02     = res_reg[2];
    assign inv.inv11     = res_reg[3];
    assign inv.inv12     = res_reg[4];
    assign inv.inv22     = res_reg[5];
    assign inv.singular  = sing_reg;
    assign inv.saturated = sat_reg;
endmodule

FILE: rtl/s3i_div_step.sv
// one registered restoring-division step producing quotient bit K
module s3i_div_step #(
    parameter int W  = 32,
    parameter int DW = 130,
    parameter int K  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [DW-1:0]        rem_in,
    input  logic [DW-1:0]        dvs_in,
    input  logic [W-1:0]         q_in,
    input  s3i_pkg::s3i_div_ctl_t ctl_in,
    output logic [DW-1:0]        rem_out,
    output logic [W-1:0]         q_out,
    output s3i_pkg::s3i_div_ctl_t ctl_out
);
    import s3i_pkg::*;

    logic [DW-1:0] shifted;
    logic          take;
    logic [DW-1:0] rem_next;
    logic [W-1:0]  q_next;
    logic [DW-1:0] rem_reg;
    logic [W-1:0]  q_reg;
    s3i_div_ctl_t  ctl_reg;

    // trial subtract of the divisor aligned to this bit
    always_comb
    begin
        shifted  = dvs_in << K;
        take     = (rem_in >= shifted);
        rem_next = take ? (rem_in - shifted) : rem_in;
        q_next   = q_in;
        q_next[K] = take;
    end

    // control travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign ctl_out = ctl_reg;
endmodule

FILE: rtl/s3i_checker.sv
// port-level checks for the symmetric 3x3 inverse, bound to the top level
module s3i_checker #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         mat_ready,
    input logic         inv_valid,
    input logic         inv_ready,
    input logic [W-1:0] inv00,
    input logic [W-1:0] inv01,
    input logic [W-1:0] inv02,
    input logic [W-1:0] inv11,
    input logic [W-1:0] inv12,
    input logic [W-1:0] inv22,
    input logic         singular,
    input logic         saturated
);
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

    logic all_zero;
    logic any_ext;

    // summary of the result beat
    assign all_zero = (inv00 == '0) && (inv01 == '0) && (inv02 == '0) &&
                      (inv11 == '0) && (inv12 == '0) && (inv22 == '0);
    assign any_ext  = (inv00 == MAXPOS) || (inv00 == MINNEG) ||
                      (inv01 == MAXPOS) || (inv01 == MINNEG) ||
                      (inv02 == MAXPOS) || (inv02 == MINNEG) ||
                      (inv11 == MAXPOS) || (inv11 == MINNEG) ||
                      (inv12 == MAXPOS) || (inv12 == MINNEG) ||
                      (inv22 == MAXPOS) || (inv22 == MINNEG);

    // a held result beat stays put (checked on inv00 and inv22)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && !inv_ready |=> inv_valid && $stable(inv00) && $stable(inv22))
        else $error("result beat changed while stalled");

    // a draining output never blocks the input side
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        inv_ready |-> mat_ready)
        else $error("input stalled while output is taken");

    // singular results are zero and not clipped
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && singular |-> all_zero && !saturated)
        else $error("singular beat with nonzero entries or clip flag");

    // a clip flag means some entry sits at a range limit and the beat is not singular
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && saturated |-> any_ext && !singular)
        else $error("clip flag without a limit value");
endmodule

bind symmetric_3x3_inverse s3i_checker #(.W(DATA_WIDTH)) u_s3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_ready (mat.ready),
    .inv_valid (inv.valid),
    .inv_ready (inv.ready),
    .inv00     (inv.inv00),
    .inv01     (inv.inv01),
    .inv02     (inv.inv02),
    .inv11     (inv.inv11),
    .inv12     (inv.inv12),
    .inv22     (inv.inv22),
    .singular  (inv.singular),
    .saturated (inv.saturated)
);
